[src/ffws_pkg.sv]
// shared types and constants of the first-fit word store
// no dependencies
package ffws_pkg;

    localparam int MAX_WORDS  = 1024;
    localparam int INIT_WORDS = 8;
    localparam int WORD_W     = 32;
    localparam int ADDR_W     = $clog2(MAX_WORDS);
    localparam int CNT_W      = ADDR_W + 1;
    localparam int LEN_W      = 10;

    localparam logic [CNT_W-1:0] CAP_MAX  = CNT_W'(MAX_WORDS);
    localparam logic [CNT_W-1:0] CAP_HALF = CNT_W'(MAX_WORDS / 2);
    localparam logic [CNT_W-1:0] CAP_INIT = CNT_W'(INIT_WORDS);

    typedef enum logic [1:0] {
        KIND_ALLOC  = 2'd0,
        KIND_VALUE  = 2'd1,
        KIND_SHRINK = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_ROOM = 2'd1,
        ST_NO_LIST = 2'd2,
        ST_LOADING = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ALLOC,
        S_SHRINK,
        S_RESP
    } t_state;

    typedef struct packed {
        t_status            status;
        logic [ADDR_W-1:0]  position;
        logic [CNT_W-1:0]   capacity;
        logic [CNT_W-1:0]   usage;
    } t_result;

    typedef struct packed {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [WORD_W-1:0]  wdata;
        logic [ADDR_W-1:0]  raddr;
    } t_ram_req;

endpackage

[src/ffws_ram.sv]
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module ffws_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/ffws_ctrl.sv]
// control of the word store: clearing pass, first-fit scan, shrink scan, value writes
// depends on ffws_pkg; drives the word ram through a t_ram_req struct
module ffws_ctrl import ffws_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_kind             i_kind,
    input  logic [LEN_W-1:0]  i_len,
    input  logic [WORD_W-1:0] i_value,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res,
    output t_ram_req          o_ram,
    input  logic [WORD_W-1:0] i_rdata
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_addr, n_addr;
    logic               r_pvld, n_pvld;
    logic [ADDR_W-1:0]  r_pidx, n_pidx;
    logic [CNT_W-1:0]   r_run, n_run;
    logic [CNT_W-1:0]   r_need, n_need;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [CNT_W-1:0]   r_cap, n_cap;
    logic [CNT_W-1:0]   r_usage, n_usage;
    logic [ADDR_W-1:0]  r_fill, n_fill;
    logic [LEN_W-1:0]   r_remain, n_remain;
    t_result            r_res, n_res;

    logic               zero_word;
    logic               last_word;
    logic [CNT_W-1:0]   run_inc;
    logic [CNT_W-1:0]   start;
    logic [CNT_W:0]     usage_sum;
    logic [CNT_W-1:0]   usage_new;
    logic [CNT_W-1:0]   cap_shrunk;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_pvld   <= 1'b0;
            r_cap    <= CAP_INIT;
            r_usage  <= '0;
            r_fill   <= '0;
            r_remain <= '0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_pvld   <= n_pvld;
            r_cap    <= n_cap;
            r_usage  <= n_usage;
            r_fill   <= n_fill;
            r_remain <= n_remain;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pidx <= n_pidx;
        r_run  <= n_run;
        r_need <= n_need;
        r_len  <= n_len;
        r_res  <= n_res;
    end

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_pvld      = 1'b0;
        n_pidx      = r_pidx;
        n_run       = r_run;
        n_need      = r_need;
        n_len       = r_len;
        n_cap       = r_cap;
        n_usage     = r_usage;
        n_fill      = r_fill;
        n_remain    = r_remain;
        n_res       = r_res;
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;
        o_ram       = '0;
        o_ram.raddr = r_addr[ADDR_W-1:0];

        zero_word  = (i_rdata == '0);
        last_word  = ({1'b0, r_pidx} == (r_cap - CNT_W'(1)));
        run_inc    = zero_word ? (r_run + CNT_W'(1)) : '0;
        start      = {1'b0, r_pidx} + CNT_W'(1) - r_need;
        usage_sum  = {1'b0, r_usage} + {1'b0, r_need};
        usage_new  = (usage_sum > {1'b0, CAP_MAX}) ? CAP_MAX : usage_sum[CNT_W-1:0];
        cap_shrunk = ((r_cap >> 1) >= CAP_INIT) ? (r_cap >> 1) : r_cap;

        case (r_state)
            S_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_addr[ADDR_W-1:0];
                n_addr      = r_addr + CNT_W'(1);
                if (r_addr == CAP_MAX - CNT_W'(1)) begin
                    n_addr  = '0;
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_res.status   = ST_OK;
                    n_res.position = '0;
                    n_res.capacity = r_cap;
                    n_res.usage    = r_usage;
                    n_state        = S_RESP;
                    case (i_kind)
                        KIND_ALLOC: begin
                            if (r_remain != '0) begin
                                n_res.status   = ST_LOADING;
                                n_res.position = r_fill;
                            end else begin
                                n_need  = {1'b0, i_len} + CNT_W'(1);
                                n_len   = i_len;
                                n_addr  = '0;
                                n_run   = '0;
                                n_state = S_ALLOC;
                            end
                        end
                        KIND_VALUE: begin
                            if (r_remain == '0) begin
                                n_res.status = ST_NO_LIST;
                            end else begin
                                o_ram.we       = 1'b1;
                                o_ram.waddr    = r_fill;
                                o_ram.wdata    = i_value;
                                n_res.position = r_fill;
                                n_fill         = r_fill + ADDR_W'(1);
                                n_remain       = r_remain - LEN_W'(1);
                            end
                        end
                        KIND_SHRINK: begin
                            if (r_remain != '0) begin
                                n_res.status = ST_LOADING;
                            end else begin
                                n_addr  = r_cap >> 2;
                                n_state = S_SHRINK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_ALLOC: begin
                if (r_addr < r_cap) begin
                    n_pvld = 1'b1;
                    n_pidx = r_addr[ADDR_W-1:0];
                    n_addr = r_addr + CNT_W'(1);
                end
                if (r_pvld) begin
                    n_run = run_inc;
                    if (zero_word && (run_inc == r_need)) begin
                        o_ram.we       = 1'b1;
                        o_ram.waddr    = start[ADDR_W-1:0];
                        o_ram.wdata    = WORD_W'(r_len);
                        n_usage        = usage_new;
                        n_fill         = start[ADDR_W-1:0] + ADDR_W'(1);
                        n_remain       = r_len;
                        n_res.status   = ST_OK;
                        n_res.position = start[ADDR_W-1:0];
                        n_res.capacity = r_cap;
                        n_res.usage    = usage_new;
                        n_pvld         = 1'b0;
                        n_state        = S_RESP;
                    end else if (last_word) begin
                        // grown words are known zero, the scan just runs on
                        if (r_cap <= CAP_HALF) begin
                            n_cap = r_cap << 1;
                        end else begin
                            n_res.status   = ST_NO_ROOM;
                            n_res.position = '0;
                            n_res.capacity = r_cap;
                            n_res.usage    = r_usage;
                            n_pvld         = 1'b0;
                            n_state        = S_RESP;
                        end
                    end
                end
            end

            S_SHRINK: begin
                if (r_addr < r_cap) begin
                    n_pvld = 1'b1;
                    n_pidx = r_addr[ADDR_W-1:0];
                    n_addr = r_addr + CNT_W'(1);
                end
                if (r_pvld) begin
                    if (!zero_word) begin
                        n_pvld  = 1'b0;
                        n_state = S_RESP;
                    end else if (last_word) begin
                        n_cap          = cap_shrunk;
                        n_res.capacity = cap_shrunk;
                        n_pvld         = 1'b0;
                        n_state        = S_RESP;
                    end
                end
            end

            S_RESP: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_CLEAR;
                n_addr  = '0;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

[src/ffws_out.sv]
// output register stage between the controller and the result stream
// depends on ffws_pkg for the t_result struct
module ffws_out import ffws_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_res,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_res
);

    logic    r_vld;
    t_result r_data;

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= i_res;
        end
    end

    assign o_valid = r_vld;
    assign o_res   = r_data;

endmodule

[src/first_fit_word_store.sv]
// first-fit word store: value, stray and unused-kind items are held in the controller result
// register during S_RESP and then move to the output register; allocate scans one word per cycle,
// doubling capacity when it reaches the last word with no fit; shrink check scans the top 3/4 of capacity
// one item in work at a time, taken once the previous result sits in the output register;
// synchronous active-low reset, then a clearing pass over all MAX_WORDS (1024) words with no
// item taken; depends on ffws_pkg, ffws_ram, ffws_ctrl, ffws_out
module first_fit_word_store import ffws_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // list_length[9:0], value[41:10], zero pad
    input  logic [1:0]  s_axis_tuser,   // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // position[9:0], capacity[20:10], usage[31:21]
    output logic [1:0]  m_axis_tuser    // status[1:0]
);

    t_ram_req          ram_req;
    logic [WORD_W-1:0] ram_rdata;
    logic              res_valid;
    logic              res_ready;
    t_result           res;
    t_result           out_res;

    ffws_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WORDS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    ffws_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_kind      (t_kind'(s_axis_tuser)),
        .i_len       (s_axis_tdata[9:0]),
        .i_value     (s_axis_tdata[41:10]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .o_ram       (ram_req),
        .i_rdata     (ram_rdata)
    );

    ffws_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (res_valid),
        .o_ready (res_ready),
        .i_res   (res),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {out_res.usage, out_res.capacity, out_res.position};
    assign m_axis_tuser = out_res.status;

endmodule

[dv/tb_top.sv]
`timescale 1ns / 100ps
// self-checking testbench of first_fit_word_store: directed and random item streams
// are checked against an in-bench shadow of the word store, with bursty input and stalling output
// depends on ffws_pkg and the first_fit_word_store rtl
module tb_top import ffws_pkg::*; ();

    localparam int IDLE_LIMIT   = 10000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 2000;
    localparam int HOLD_AT      = 150;

    typedef struct packed {
        t_kind              kind;
        logic [LEN_W-1:0]   len;
        logic [WORD_W-1:0]  val;
    } t_item;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;   // list_length[9:0], value[41:10], zero pad
    logic [1:0]  s_axis_tuser  = '0;   // kind[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;         // position[9:0], capacity[20:10], usage[31:21]
    logic [1:0]  m_axis_tuser;         // status[1:0]

    t_item   pending_items[$];
    t_result replies_due[$];

    // shadow of the block state
    logic [WORD_W-1:0] shadow_mem [MAX_WORDS];
    int shadow_cap   = INIT_WORDS;
    int shadow_usage = 0;
    int shadow_fill  = 0;
    int shadow_left  = 0;

    t_item cur_item;
    int    burst_left = 0;
    int    gap_left   = 0;
    int    kind_sent [4] = '{0, 0, 0, 0};

    int stall_mode   = 0;
    int stretch_left = 0;
    int hold_left    = 0;
    bit hold_done    = 1'b0;
    int results_seen = 0;
    int mismatches   = 0;
    int status_seen [4] = '{0, 0, 0, 0};
    int cap_peak     = 0;
    int usage_peak   = 0;
    int idle_cycles  = 0;

    first_fit_word_store dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    task automatic predict_reply(input t_item it);
        t_result r;
        int      need;
        int      run_len;
        int      start;
        int      j;
        bit      found;
        bit      searching;
        bit      empty;
        r.status   = ST_OK;
        r.position = '0;
        start      = 0;
        case (it.kind)
            KIND_ALLOC: begin
                if (shadow_left != 0) begin
                    r.status   = ST_LOADING;
                    r.position = ADDR_W'(shadow_fill);
                end else begin
                    need      = int'(it.len) + 1;
                    found     = 1'b0;
                    searching = 1'b1;
                    while (searching) begin
                        run_len = 0;
                        for (j = 0; j < shadow_cap && !found; j++) begin
                            if (shadow_mem[j] == '0) begin
                                run_len++;
                                if (run_len == need) begin
                                    found = 1'b1;
                                    start = j + 1 - need;
                                end
                            end else begin
                                run_len = 0;
                            end
                        end
                        if (found || shadow_cap * 2 > MAX_WORDS) begin
                            searching = 1'b0;
                        end else begin
                            for (j = shadow_cap; j < shadow_cap * 2; j++) shadow_mem[j] = '0;
                            shadow_cap = shadow_cap * 2;
                        end
                    end
                    if (found) begin
                        shadow_mem[start] = WORD_W'(it.len);
                        shadow_usage      = shadow_usage + need;
                        if (shadow_usage > MAX_WORDS) shadow_usage = MAX_WORDS;
                        shadow_fill       = start + 1;
                        shadow_left       = int'(it.len);
                        r.position        = ADDR_W'(start);
                    end else begin
                        r.status = ST_NO_ROOM;
                    end
                end
            end
            KIND_VALUE: begin
                if (shadow_left == 0) begin
                    r.status = ST_NO_LIST;
                end else begin
                    if (shadow_fill < MAX_WORDS) shadow_mem[shadow_fill] = it.val;
                    r.position  = ADDR_W'(shadow_fill);
                    shadow_fill = shadow_fill + 1;
                    shadow_left = shadow_left - 1;
                end
            end
            KIND_SHRINK: begin
                if (shadow_left != 0) begin
                    r.status = ST_LOADING;
                end else begin
                    empty = 1'b1;
                    for (j = shadow_cap / 4; j < shadow_cap; j++) begin
                        if (shadow_mem[j] != '0) empty = 1'b0;
                    end
                    if (empty && shadow_cap / 2 >= INIT_WORDS) shadow_cap = shadow_cap / 2;
                end
            end
            default: begin
            end
        endcase
        r.capacity = CNT_W'(shadow_cap);
        r.usage    = CNT_W'(shadow_usage);
        replies_due.push_back(r);
    endtask

    function automatic logic [WORD_W-1:0] pick_value(input int zero_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < zero_pct) return '0;
        if (r < zero_pct + 8) begin
            case ($urandom_range(0, 3))
                0: return 32'h8000_0000;
                1: return 32'hffff_ffff;
                2: return 32'h7fff_ffff;
                default: return 32'd1;
            endcase
        end
        return WORD_W'($urandom);
    endfunction

    // fields that the kind does not use carry random bits
    task automatic push_item(input t_kind k, input int len, input logic [WORD_W-1:0] v);
        t_item it;
        it.kind = k;
        it.len  = (k == KIND_ALLOC) ? LEN_W'(len) : LEN_W'($urandom);
        it.val  = (k == KIND_VALUE) ? v : WORD_W'($urandom);
        pending_items.push_back(it);
    endtask

    task automatic push_list(input int len, input int zero_pct);
        int i;
        push_item(KIND_ALLOC, len, '0);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 99) < 3) begin
                case ($urandom_range(0, 2))
                    0: push_item(KIND_ALLOC, $urandom_range(0, 1023), '0);
                    1: push_item(KIND_SHRINK, 0, '0);
                    default: push_item(KIND_NONE, 0, '0);
                endcase
            end
            push_item(KIND_VALUE, 0, pick_value(zero_pct));
        end
        if ($urandom_range(0, 99) < 5) push_item(KIND_VALUE, 0, pick_value(zero_pct));
    endtask

    initial begin : stimulus
        int i;
        int choice;
        int len;
        for (i = 0; i < MAX_WORDS; i++) shadow_mem[i] = '0;

        // directed: floor, stray and unused kinds, zero length, loading, doubling, no room
        push_item(KIND_VALUE, 0, 32'hdead_beef);
        push_item(KIND_SHRINK, 0, '0);
        push_item(KIND_NONE, 0, '0);
        push_item(KIND_ALLOC, 0, '0);
        push_item(KIND_ALLOC, 0, '0);
        push_item(KIND_ALLOC, 2, '0);
        push_item(KIND_ALLOC, 5, '0);
        push_item(KIND_SHRINK, 0, '0);
        push_item(KIND_VALUE, 0, 32'h8000_0000);
        push_item(KIND_VALUE, 0, 32'h0000_0000);
        push_item(KIND_VALUE, 0, 32'h0000_0001);
        push_item(KIND_ALLOC, 6, '0);
        push_item(KIND_VALUE, 0, 32'hffff_ffff);
        push_item(KIND_VALUE, 0, 32'h7fff_ffff);
        push_item(KIND_VALUE, 0, 32'h0000_0001);
        push_item(KIND_VALUE, 0, 32'h5555_5555);
        push_item(KIND_VALUE, 0, 32'haaaa_aaaa);
        push_item(KIND_VALUE, 0, 32'h1234_5678);
        push_item(KIND_ALLOC, 1023, '0);
        for (i = 0; i < 6; i++) push_item(KIND_SHRINK, 0, '0);

        // random: mostly complete lists, some noise, long zero-heavy lists
        while (pending_items.size() < 580) begin
            choice = $urandom_range(0, 99);
            if (choice < 70) begin
                len = $urandom_range(0, 99);
                if (len < 10) begin
                    len = 0;
                end else if (len < 65) begin
                    len = $urandom_range(1, 6);
                end else if (len < 90) begin
                    len = $urandom_range(7, 40);
                end else if (len < 97) begin
                    len = $urandom_range(60, 150);
                end else begin
                    len = -1;
                end
                if (len < 0) begin
                    push_item(KIND_ALLOC, $urandom_range(1016, 1023), '0);
                end else begin
                    push_list(len, (len >= 60) ? 90 : 40);
                end
            end else if (choice < 85) begin
                push_item(KIND_SHRINK, 0, '0);
            end else if (choice < 92) begin
                push_item(KIND_VALUE, 0, pick_value(30));
            end else if (choice < 96) begin
                push_item(KIND_NONE, 0, '0);
            end else begin
                for (i = 0; i < 3; i++) push_item(KIND_SHRINK, 0, '0);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (pending_items.size() != 0 || s_axis_tvalid || replies_due.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("items sent: %0d allocate, %0d value, %0d shrink check, %0d unused kind",
                 kind_sent[KIND_ALLOC], kind_sent[KIND_VALUE], kind_sent[KIND_SHRINK],
                 kind_sent[KIND_NONE]);
        $display("ok %0d, no room %0d, stray %0d, loading %0d, peak capacity %0d, usage %0d",
                 status_seen[ST_OK], status_seen[ST_NO_ROOM], status_seen[ST_NO_LIST],
                 status_seen[ST_LOADING], cap_peak, usage_peak);
        if (mismatches == 0) begin
            $display("first_fit_word_store regression: pass");
        end else begin
            $display("first_fit_word_store regression: fail");
        end
        $finish;
    end

    // sender: bursts of items with random gaps
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                predict_reply(cur_item);
                kind_sent[cur_item.kind]++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (burst_left > 0 && pending_items.size() > 0) begin
                    cur_item = pending_items.pop_front();
                    s_axis_tdata  <= {6'b0, cur_item.val, cur_item.len};
                    s_axis_tuser  <= cur_item.kind;
                    s_axis_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                        if (gap_left == 0) burst_left = $urandom_range(1, 40);
                    end
                end else begin
                    s_axis_tvalid <= 1'b0;
                    if (gap_left > 0) gap_left--;
                    else if (burst_left == 0) burst_left = $urandom_range(1, 40);
                end
            end
        end
    end

    // receiver: stall pattern changes per stretch, one long hold-off
    always @(posedge i_clk) begin : receiver
        t_result got;
        t_result want;
        bit      ready_next;
        if (m_axis_tvalid && m_axis_tready) begin
            got.status   = t_status'(m_axis_tuser);
            got.position = m_axis_tdata[9:0];
            got.capacity = m_axis_tdata[20:10];
            got.usage    = m_axis_tdata[31:21];
            results_seen++;
            status_seen[got.status]++;
            if (int'(got.capacity) > cap_peak) cap_peak = int'(got.capacity);
            if (int'(got.usage) > usage_peak) usage_peak = int'(got.usage);
            if (replies_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: status %0d position %0d capacity %0d usage %0d",
                             got.status, got.position, got.capacity, got.usage);
            end else begin
                want = replies_due.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("result %0d expected: status %0d pos %0d cap %0d usage %0d",
                                 results_seen, want.status, want.position, want.capacity,
                                 want.usage);
                        $display("result %0d got:      status %0d pos %0d cap %0d usage %0d",
                                 results_seen, got.status, got.position, got.capacity,
                                 got.usage);
                    end
                end
            end
        end
        if (hold_left > 0) begin
            hold_left--;
        end else if (!hold_done && results_seen >= HOLD_AT) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (stretch_left == 0) begin
            stall_mode   = $urandom_range(0, 3);
            stretch_left = $urandom_range(20, 200);
        end else begin
            stretch_left--;
        end
        case (stall_mode)
            0: ready_next = 1'b1;
            1: ready_next = ($urandom_range(0, 9) < 7);
            2: ready_next = ($urandom_range(0, 9) < 3);
            default: ready_next = ~m_axis_tready;
        endcase
        if (hold_left > 0) ready_next = 1'b0;
        m_axis_tready <= ready_next;
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("no item moved for %0d cycles, %0d results outstanding, %0d items unsent",
                     idle_cycles, replies_due.size(), pending_items.size());
            $display("first_fit_word_store regression: fail");
            $finish;
        end
    end

endmodule
